// File: rtl/ssc_pkg.sv
package ssc_pkg;

    // Block geometry
    localparam int BLOCK_ROWS = 16;
    localparam int SLOTS      = 4;
    localparam int LANES      = 4;

    // Field widths fixed by the interface
    localparam int VALUE_W = 32;
    localparam int ROW_W   = 4;

    // Derived widths
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W    = $clog2(SLOTS + 1);
    localparam int NUM_BANKS = 2;
    localparam int RAM_DEPTH = NUM_BANKS * SLOTS;
    localparam int ENTRY_W   = VALUE_W + ROW_W;

    // One stored slot entry of one lane
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [ROW_W-1:0]   row;
    } entry_t;

    // Input transaction payload
    typedef struct packed {
        logic [31:0] value_lane0;
        logic [31:0] value_lane1;
        logic [31:0] value_lane2;
        logic [31:0] value_lane3;
        logic [3:0]  present_mask;
    } in_item_t;

    // Result transaction payload
    typedef struct packed {
        logic [1:0]  slot_number;
        logic [31:0] slot_value_lane0;
        logic [31:0] slot_value_lane1;
        logic [31:0] slot_value_lane2;
        logic [31:0] slot_value_lane3;
        logic [3:0]  row_index_lane0;
        logic [3:0]  row_index_lane1;
        logic [3:0]  row_index_lane2;
        logic [3:0]  row_index_lane3;
        logic [3:0]  overflow_mask;
        logic        last_slot;
    } out_item_t;

    // Slot writes of one row, one port per lane memory
    typedef struct packed {
        logic [LANES-1:0]             en;
        logic [LANES-1:0][SLOT_W-1:0] slot;
        logic                         bank;
        entry_t [LANES-1:0]           data;
    } lane_wr_t;

    // Summary of a finished block, handed to the emitter
    typedef struct packed {
        logic                         valid;
        logic                         bank;
        logic [LANES-1:0][FILL_W-1:0] fill;
        logic [LANES-1:0]             ovf;
    } blk_done_t;

endpackage

// File: rtl/ssc_lane_ram.sv
module ssc_lane_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/ssc_fill.sv
module ssc_fill import ssc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    input  logic [NUM_BANKS-1:0] bank_busy,
    output lane_wr_t             wr,
    output blk_done_t            done
);

    logic [ROW_W-1:0]             row_reg, row_next;
    logic [LANES-1:0][FILL_W-1:0] fill_reg, fill_next, fill_upd;
    logic [LANES-1:0]             ovf_reg, ovf_next, ovf_hit;
    logic                         bank_reg, bank_next;
    logic [LANES-1:0][VALUE_W-1:0] vals;
    logic                         accept, last_row;

    // Stall while the bank to be filled still waits for emission
    assign s_ready  = !bank_busy[bank_reg];
    assign accept   = s_valid && s_ready;
    assign last_row = (row_reg == ROW_W'(BLOCK_ROWS - 1));

    assign vals[0] = s_data.value_lane0;
    assign vals[1] = s_data.value_lane1;
    assign vals[2] = s_data.value_lane2;
    assign vals[3] = s_data.value_lane3;

    // Allocate the next free slot per lane
    always_comb begin
        wr.bank = bank_reg;
        for (int l = 0; l < LANES; l++) begin
            logic room, here, nz, take;
            room = (fill_reg[l] < FILL_W'(SLOTS));
            here = s_data.present_mask[l];
            nz   = |vals[l][VALUE_W-2:0];
            take = room && (!here || nz);
            ovf_hit[l]       = here && nz && !room;
            wr.en[l]         = accept && take;
            wr.slot[l]       = fill_reg[l][SLOT_W-1:0];
            wr.data[l].value = here ? vals[l] : '0;
            wr.data[l].row   = row_reg;
            fill_upd[l]      = take ? fill_reg[l] + 1'b1 : fill_reg[l];
        end
    end

    // Report the block summary on its last row
    always_comb begin
        done.valid = accept && last_row;
        done.bank  = bank_reg;
        done.fill  = fill_upd;
        done.ovf   = ovf_reg | ovf_hit;
    end

    // Advance row, fill counts, overflow flags and the fill bank
    always_comb begin
        row_next  = row_reg;
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        bank_next = bank_reg;
        if (accept) begin
            if (last_row) begin
                row_next  = '0;
                fill_next = '0;
                ovf_next  = '0;
                bank_next = !bank_reg;
            end else begin
                row_next  = row_reg + 1'b1;
                fill_next = fill_upd;
                ovf_next  = ovf_reg | ovf_hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            fill_reg <= '0;
            ovf_reg  <= '0;
            bank_reg <= 1'b0;
        end else begin
            row_reg  <= row_next;
            fill_reg <= fill_next;
            ovf_reg  <= ovf_next;
            bank_reg <= bank_next;
        end
    end

endmodule

// File: rtl/ssc_emit.sv
module ssc_emit import ssc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  blk_done_t            done,
    output logic [NUM_BANKS-1:0] bank_busy,
    output logic                 rd_en,
    output logic [SLOT_W:0]      rd_addr,
    input  entry_t [LANES-1:0]   rd_q,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data
);

    logic [NUM_BANKS-1:0]                        pend_reg, pend_next;
    logic [NUM_BANKS-1:0][LANES-1:0][FILL_W-1:0] bfill_reg;
    logic [NUM_BANKS-1:0][LANES-1:0]             bovf_reg;
    logic                                        ebank_reg, ebank_next;
    logic [SLOT_W-1:0]                           slot_reg, slot_next;
    logic                                        rd_valid_reg, rd_valid_next;
    logic [SLOT_W-1:0]                           rd_slot_reg;
    logic [LANES-1:0][FILL_W-1:0]                rd_fill_reg;
    logic [LANES-1:0]                            rd_ovf_reg;
    logic                                        m_valid_reg, m_valid_next;
    out_item_t                                   m_data_reg, m_data_next;
    logic                                        out_free, issue, slot_last;
    entry_t [LANES-1:0]                          masked;

    assign bank_busy = pend_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign issue     = pend_reg[ebank_reg] && (!rd_valid_reg || out_free);
    assign slot_last = (slot_reg == SLOT_W'(SLOTS - 1));
    assign rd_en     = issue;
    assign rd_addr   = {ebank_reg, slot_reg};

    // Track pending banks and walk the slots of the oldest one
    always_comb begin
        pend_next     = pend_reg;
        ebank_next    = ebank_reg;
        slot_next     = slot_reg;
        rd_valid_next = rd_valid_reg;
        if (issue) begin
            rd_valid_next = 1'b1;
            if (slot_last) begin
                slot_next            = '0;
                pend_next[ebank_reg] = 1'b0;
                ebank_next           = !ebank_reg;
            end else begin
                slot_next = slot_reg + 1'b1;
            end
        end else if (out_free) begin
            rd_valid_next = 1'b0;
        end
        if (done.valid) begin
            pend_next[done.bank] = 1'b1;
        end
    end

    // Drop entries beyond the lane's fill count
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (FILL_W'(rd_slot_reg) < rd_fill_reg[l]) begin
                masked[l] = rd_q[l];
            end else begin
                masked[l] = '0;
            end
        end
    end

    // Load the output register when it frees up
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_free) begin
            m_valid_next = rd_valid_reg;
        end
        if (out_free && rd_valid_reg) begin
            m_data_next.slot_number      = 2'(rd_slot_reg);
            m_data_next.slot_value_lane0 = masked[0].value;
            m_data_next.slot_value_lane1 = masked[1].value;
            m_data_next.slot_value_lane2 = masked[2].value;
            m_data_next.slot_value_lane3 = masked[3].value;
            m_data_next.row_index_lane0  = masked[0].row;
            m_data_next.row_index_lane1  = masked[1].row;
            m_data_next.row_index_lane2  = masked[2].row;
            m_data_next.row_index_lane3  = masked[3].row;
            m_data_next.overflow_mask    = rd_ovf_reg;
            m_data_next.last_slot        = (rd_slot_reg == SLOT_W'(SLOTS - 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= '0;
            ebank_reg    <= 1'b0;
            slot_reg     <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            pend_reg     <= pend_next;
            ebank_reg    <= ebank_next;
            slot_reg     <= slot_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Capture block summaries and per-read metadata
    always_ff @(posedge aclk) begin
        if (done.valid) begin
            bfill_reg[done.bank] <= done.fill;
            bovf_reg[done.bank]  <= done.ovf;
        end
        if (issue) begin
            rd_slot_reg <= slot_reg;
            rd_fill_reg <= bfill_reg[ebank_reg];
            rd_ovf_reg  <= bovf_reg[ebank_reg];
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        done.valid |-> !pend_reg[done.bank])
        else $error("block finished into a bank still pending emission");

    a_read_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg && !out_free |=> rd_valid_reg && $stable(rd_slot_reg))
        else $error("read stage lost its entry while output stalled");

    a_last_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.last_slot == (m_data_reg.slot_number == 2'(SLOTS - 1))))
        else $error("last_slot does not match slot number");
`endif

endmodule

// File: rtl/structured_sparsity_4of16_compressor_core.sv
// 4-of-16 structured sparsity compressor, four lanes side by side.
// Input channel s_*: one transaction per row of a 16-row block, carrying four
// IEEE single bit patterns and a present mask. Result channel m_*: four
// transactions per block, one per compressed slot, slot 0 first, last_slot
// set on slot 3. Each lane keeps its slots in a small dual-bank memory; one
// bank fills while the other is read out.
// Throughput: one row per cycle, sustained, taken every cycle s_ready is high.
// Readout: slot 0 passes the pending flag, read and output registers after
// the last row is accepted, the rest one per cycle while m_ready is high.
// Rate is set by the per-lane memory write port (one slot write per row) and
// the shared read port (one slot per cycle).
// When the receiver stalls, the output register and a read stage hold; the
// input keeps running until a block ends while the other bank is still being
// emitted, then s_ready drops at the first row of the next block.
// Reset (aresetn low, synchronous) clears row counter, fill counts, overflow
// flags and all pending emissions; memory contents need no clearing, unfilled
// slots read as zero through the saved fill counts.
module structured_sparsity_4of16_compressor_core import ssc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    lane_wr_t             wr;
    blk_done_t            done;
    logic [NUM_BANKS-1:0] bank_busy;
    logic                 rd_en;
    logic [SLOT_W:0]      rd_addr;
    entry_t [LANES-1:0]   rd_q;

    // Write side: slot allocation per row
    ssc_fill u_fill (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .bank_busy (bank_busy),
        .wr        (wr),
        .done      (done)
    );

    // Slot memories, one per lane
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        ssc_lane_ram #(
            .WIDTH (ENTRY_W),
            .DEPTH (RAM_DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (wr.en[l]),
            .waddr ({wr.bank, wr.slot[l]}),
            .wdata (wr.data[l]),
            .re    (rd_en),
            .raddr (rd_addr),
            .rdata (rd_q[l])
        );
    end

    // Read side: slot readout and output register
    ssc_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .done      (done),
        .bank_busy (bank_busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_q      (rd_q),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: sim/slot_stream_checker.sv
`timescale 1ns / 100ps

module slot_stream_checker import ssc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data,
    output int        fail_count,
    output int        pending,
    output int        slots_checked
);

    // Mirror of the compressor state
    int               row_num;
    int               fill [LANES];
    logic [31:0]      slot_val [SLOTS][LANES];
    logic [3:0]       slot_row [SLOTS][LANES];
    logic [LANES-1:0] ovf_bits;

    // Slot results still owed by the block, oldest first
    out_item_t expected_slots[$];

    // Drop everything stored for the current block
    task automatic clear_block();
        for (int l = 0; l < LANES; l++) begin
            fill[l] = 0;
            for (int s = 0; s < SLOTS; s++) begin
                slot_val[s][l] = '0;
                slot_row[s][l] = '0;
            end
        end
        ovf_bits = '0;
    endtask

    // Place one row's cells into lane slots; emit the block after its last row
    task automatic compress_row(input in_item_t row);
        logic [31:0] lane_val [LANES];
        out_item_t   res;
        lane_val[0] = row.value_lane0;
        lane_val[1] = row.value_lane1;
        lane_val[2] = row.value_lane2;
        lane_val[3] = row.value_lane3;
        for (int l = 0; l < LANES; l++) begin
            if (row.present_mask[l]) begin
                // present: only nonzero magnitudes take a slot
                if (lane_val[l][30:0] != '0) begin
                    if (fill[l] < SLOTS) begin
                        slot_val[fill[l]][l] = lane_val[l];
                        slot_row[fill[l]][l] = row_num[3:0];
                        fill[l]++;
                    end else begin
                        ovf_bits[l] = 1'b1;
                    end
                end
            end else if (fill[l] < SLOTS) begin
                // padding takes a slot with a zero value
                slot_val[fill[l]][l] = '0;
                slot_row[fill[l]][l] = row_num[3:0];
                fill[l]++;
            end
        end
        if (row_num == BLOCK_ROWS - 1) begin
            for (int s = 0; s < SLOTS; s++) begin
                res.slot_number      = s[1:0];
                res.slot_value_lane0 = slot_val[s][0];
                res.slot_value_lane1 = slot_val[s][1];
                res.slot_value_lane2 = slot_val[s][2];
                res.slot_value_lane3 = slot_val[s][3];
                res.row_index_lane0  = slot_row[s][0];
                res.row_index_lane1  = slot_row[s][1];
                res.row_index_lane2  = slot_row[s][2];
                res.row_index_lane3  = slot_row[s][3];
                res.overflow_mask    = ovf_bits;
                res.last_slot        = (s == SLOTS - 1);
                expected_slots.push_back(res);
            end
            row_num = 0;
            clear_block();
        end else begin
            row_num++;
        end
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Match one emitted slot against the oldest prediction
    task automatic check_slot(input out_item_t got);
        out_item_t want;
        slots_checked++;
        if (expected_slots.size() == 0) begin
            $display("%0t: unexpected slot transaction, expected none, actual %h",
                     $time, got);
            fail_count++;
        end else begin
            want = expected_slots.pop_front();
            compare_field("slot_number",      want.slot_number,      got.slot_number);
            compare_field("slot_value_lane0", want.slot_value_lane0, got.slot_value_lane0);
            compare_field("slot_value_lane1", want.slot_value_lane1, got.slot_value_lane1);
            compare_field("slot_value_lane2", want.slot_value_lane2, got.slot_value_lane2);
            compare_field("slot_value_lane3", want.slot_value_lane3, got.slot_value_lane3);
            compare_field("row_index_lane0",  want.row_index_lane0,  got.row_index_lane0);
            compare_field("row_index_lane1",  want.row_index_lane1,  got.row_index_lane1);
            compare_field("row_index_lane2",  want.row_index_lane2,  got.row_index_lane2);
            compare_field("row_index_lane3",  want.row_index_lane3,  got.row_index_lane3);
            compare_field("overflow_mask",    want.overflow_mask,    got.overflow_mask);
            compare_field("last_slot",        want.last_slot,        got.last_slot);
        end
    endtask

    // Sample mid-cycle: these values are the ones the next rising edge sees
    always @(negedge aclk) begin
        if (!aresetn) begin
            row_num       = 0;
            fail_count    = 0;
            slots_checked = 0;
            clear_block();
            expected_slots.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_slot(m_data);
            end
            if (s_valid && s_ready) begin
                compress_row(s_data);
            end
        end
        pending = expected_slots.size();
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ssc_pkg::*;

    localparam int RANDOM_BLOCKS = 29;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 3000;

    logic      aclk;
    logic      aresetn  = 1'b0;
    logic      s_valid  = 1'b0;
    logic      s_ready;
    in_item_t  s_data   = '0;
    logic      m_valid;
    logic      m_ready  = 1'b0;
    out_item_t m_data;

    int   fail_count;
    int   pending;
    int   slots_checked;
    int   rows_sent   = 0;
    int   burst_left  = 0;
    int   idle_cycles = 0;
    logic hold_req    = 1'b0;
    logic hold_done   = 1'b0;
    int   lane_density [LANES];
    int   pad_pct;

    structured_sparsity_4of16_compressor_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    slot_stream_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .slots_checked (slots_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Offer one row and hold it until the transaction completes
    task automatic send_row(input in_item_t row);
        logic took;
        int   gap;
        s_valid <= 1'b1;
        s_data  <= row;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        rows_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            // end of burst: some bursts run straight into the next
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // Hand-picked block: tiny and full-scale magnitudes, signed zeros, NaN and
    // infinity, an overflowing lane, a mostly empty lane and an all-padding lane
    function automatic in_item_t directed_row(input int r);
        in_item_t row;
        if (r == 0)
            row.value_lane0 = 32'h0000_0001;
        else if (r == 2)
            row.value_lane0 = 32'hFFFF_FFFF;
        else if (r % 2 == 1)
            row.value_lane0 = 32'h8000_0000;
        else
            row.value_lane0 = 32'h3F80_0000 + r;
        row.value_lane1 = (r % 2 == 1) ? 32'h8000_0000 : 32'h0000_0000;
        case (r)
            0:       row.value_lane2 = 32'h7F80_0000;
            3:       row.value_lane2 = 32'hFF80_0000;
            5:       row.value_lane2 = 32'h7FC0_0001;
            15:      row.value_lane2 = 32'h0080_0000;
            default: row.value_lane2 = 32'h0000_0000;
        endcase
        row.value_lane3  = 32'hA5A5_A5A5 ^ r;
        row.present_mask = {1'b0, 1'b1, (r != 1), 1'b1};
        return row;
    endfunction

    // Cell value: nonzero with the lane's density, else a signed zero
    function automatic logic [31:0] pick_value(input int density);
        logic [31:0] v;
        if ($urandom_range(0, 99) < density) begin
            case ($urandom_range(0, 7))
                5:       v = {$urandom_range(0, 1) == 1, 31'h7FFF_FFFF};
                6:       v = {$urandom_range(0, 1) == 1, 8'hFF, 23'h0};
                7:       v = {$urandom_range(0, 1) == 1, 31'h1};
                default: v = $urandom;
            endcase
            if (v[30:0] == '0) v[0] = 1'b1;
        end else begin
            v = {$urandom_range(0, 1) == 1, 31'h0};
        end
        return v;
    endfunction

    function automatic in_item_t random_row();
        in_item_t row;
        logic [31:0] v [LANES];
        for (int l = 0; l < LANES; l++) begin
            row.present_mask[l] = ($urandom_range(0, 99) >= pad_pct);
            // padding cells carry junk that must be ignored
            v[l] = row.present_mask[l] ? pick_value(lane_density[l]) : $urandom;
        end
        row.value_lane0 = v[0];
        row.value_lane1 = v[1];
        row.value_lane2 = v[2];
        row.value_lane3 = v[3];
        return row;
    endfunction

    // Sender: one directed block, then random blocks of varied density
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        burst_left = $urandom_range(1, 40);
        for (int r = 0; r < BLOCK_ROWS; r++) begin
            send_row(directed_row(r));
        end
        hold_req <= 1'b1;
        for (int b = 0; b < RANDOM_BLOCKS; b++) begin
            for (int l = 0; l < LANES; l++) begin
                case ($urandom_range(0, 4))
                    0:       lane_density[l] = 0;
                    1:       lane_density[l] = 10;
                    2:       lane_density[l] = 25;
                    3:       lane_density[l] = 50;
                    default: lane_density[l] = 100;
                endcase
            end
            case ($urandom_range(0, 2))
                0:       pad_pct = 0;
                1:       pad_pct = 5;
                default: pad_pct = 40;
            endcase
            for (int r = 0; r < BLOCK_ROWS; r++) begin
                send_row(random_row());
            end
        end
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Covered %0d rows in %0d blocks and %0d slot transactions,",
                 rows_sent, rows_sent / BLOCK_ROWS, slots_checked);
        $display("with sender bursts, receiver stalls and one long receiver hold.");
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Receiver: one long hold once the random part starts, else stall patterns
    initial begin
        wait (aresetn);
        forever begin
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            begin
                int mode;
                int span;
                mode = $urandom_range(0, 3);
                span = $urandom_range(16, 96);
                for (int k = 0; k < span; k++) begin
                    case (mode)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= ($urandom_range(0, 1) == 1);
                        2:       m_ready <= (k % 4 != 3);
                        default: m_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    // Watchdog: abort when no transaction moves for too long
    always @(negedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule

// File: sim.f
rtl/ssc_pkg.sv
rtl/ssc_lane_ram.sv
rtl/ssc_fill.sv
rtl/ssc_emit.sv
rtl/structured_sparsity_4of16_compressor_core.sv
sim/slot_stream_checker.sv
sim/tb_top.sv
